// ===== hdl/lbr_pkg.sv =====
// Shared constants and types for the letterbox bilinear resampler.
`default_nettype none

package lbr_pkg;

    localparam int SIDE_BITS   = 8;
    localparam int MAX_SIDE    = 1 << SIDE_BITS;
    localparam int DIM_W       = SIDE_BITS + 1;
    localparam int WEIGHT_BITS = 8;
    localparam int PIX_W       = 24;

    // Scaled source position numerator and its quotient.
    localparam int N_W      = 2 * SIDE_BITS + WEIGHT_BITS;
    localparam int Q_W      = SIDE_BITS + WEIGHT_BITS;
    localparam int RECIP_K  = N_W;
    localparam int RECIP_W  = N_W + 1;

    // Shared iterative divider widths.
    localparam int DIV_W     = RECIP_W;
    localparam int DVS_W     = DIM_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Four banks split by the parity of column and line.
    localparam int BANK_AW    = 2 * SIDE_BITS - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PRESENT = 3'd5;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [DIM_W-1:0]   src;
        logic [DIM_W-1:0]   fit;
        logic [RECIP_W-1:0] recip;
    } loc_cfg_t;

    typedef struct packed {
        logic                 op;
        logic                 in_box;
        logic [SIDE_BITS-1:0] col;
        logic [SIDE_BITS-1:0] row;
        logic [PIX_W-1:0]     pixel;
    } side_t;

endpackage

`default_nettype wire

// ===== hdl/letterbox_bilinear_resampler_unit.sv =====
// Top level of the letterbox bilinear resampler: geometry, frame store and blend pipeline.
`default_nettype none

// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   operation, column, line, pixel_in
// out       source     out_valid/out_stall pixel_out, inside_box
// cfg       sink       cfg_write           cfg_index, cfg_data
//
// One beat enters per cycle while in_stall is low; a sample beat gives one
// output beat, a load none. The ten stages are the input register, box test,
// source position pipeline (multiply, reciprocal multiply, correction, clamp),
// registered store read, two blend multiplies and output register.
// After reset and after every configuration write the box geometry is
// recomputed by a shared one-bit-per-cycle divider over three divisions,
// during which in_stall stays high.
// When out_stall holds a waiting beat, the whole pipeline freezes.

module letterbox_bilinear_resampler_unit
    import lbr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    input  wire logic [SIDE_BITS-1:0]  column,
    input  wire logic [SIDE_BITS-1:0]  line,
    input  wire logic [PIX_W-1:0]      pixel_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIX_W-1:0]           pixel_out,
    output logic                       inside_box,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] G_CMP  = 3'd0;
    localparam logic [2:0] G_FIT  = 3'd1;
    localparam logic [2:0] G_FITW = 3'd2;
    localparam logic [2:0] G_RX   = 3'd3;
    localparam logic [2:0] G_RXW  = 3'd4;
    localparam logic [2:0] G_RY   = 3'd5;
    localparam logic [2:0] G_RYW  = 3'd6;
    localparam logic [2:0] G_IDLE = 3'd7;

    localparam int H_W = 8 + WEIGHT_BITS + 1;
    localparam int V_W = H_W + WEIGHT_BITS + 1;
    localparam logic [WEIGHT_BITS:0] ONE = (WEIGHT_BITS + 1)'(1 << WEIGHT_BITS);
    localparam logic [DIM_W-1:0] SIDE_MAX = DIM_W'(MAX_SIDE);

    // Configuration registers.
    logic [DIM_W-1:0] src_w_reg;
    logic [DIM_W-1:0] src_h_reg;
    logic [DIM_W-1:0] tgt_w_reg;
    logic [DIM_W-1:0] tgt_h_reg;
    logic [PIX_W-1:0] pad_reg;
    logic             present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= SIDE_MAX;
            src_h_reg   <= SIDE_MAX;
            tgt_w_reg   <= SIDE_MAX;
            tgt_h_reg   <= SIDE_MAX;
            pad_reg     <= '0;
            present_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:   src_w_reg   <= cfg_data[DIM_W-1:0];
                REG_SOURCE_HEIGHT:  src_h_reg   <= cfg_data[DIM_W-1:0];
                REG_TARGET_WIDTH:   tgt_w_reg   <= cfg_data[DIM_W-1:0];
                REG_TARGET_HEIGHT:  tgt_h_reg   <= cfg_data[DIM_W-1:0];
                REG_PAD_COLOR:      pad_reg     <= cfg_data[PIX_W-1:0];
                REG_SOURCE_PRESENT: present_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Source sides saturate at the store size.
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic             geo_active;

    assign sw = (src_w_reg > SIDE_MAX) ? SIDE_MAX : src_w_reg;
    assign sh = (src_h_reg > SIDE_MAX) ? SIDE_MAX : src_h_reg;
    assign geo_active = present_reg && (sw != '0) && (sh != '0)
                        && (tgt_w_reg != '0) && (tgt_h_reg != '0);

    // Box geometry sequencer: aspect compare, rounded fit, then the two
    // reciprocals used by the position pipelines.
    logic [2:0]           gstate_reg;
    logic [2:0]           gstate_next;
    logic                 wl_reg;
    logic [DIM_W-1:0]     fw_reg;
    logic [DIM_W-1:0]     fh_reg;
    logic [SIDE_BITS-1:0] ox_reg;
    logic [SIDE_BITS-1:0] oy_reg;
    logic [RECIP_W-1:0]   rx_reg;
    logic [RECIP_W-1:0]   ry_reg;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic [2*DIM_W-1:0]   cross_a;
    logic [2*DIM_W-1:0]   cross_b;
    logic [DIV_W-1:0]     fit_num;
    logic [DIM_W-1:0]     fit_lim;
    logic [DIM_W-1:0]     fit_val;
    logic [DIM_W-1:0]     ox_diff;
    logic [DIM_W-1:0]     oy_diff;
    logic                 geo_busy;

    lbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        cross_a = (2*DIM_W)'(tgt_w_reg) * (2*DIM_W)'(sh);
        cross_b = (2*DIM_W)'(tgt_h_reg) * (2*DIM_W)'(sw);
        if (wl_reg)
        begin
            fit_num = (DIV_W'(cross_a) << 1) + DIV_W'(sw);
            fit_lim = tgt_h_reg;
        end
        else
        begin
            fit_num = (DIV_W'(cross_b) << 1) + DIV_W'(sh);
            fit_lim = tgt_w_reg;
        end
        if (div_rsp.quotient == '0)
            fit_val = DIM_W'(1);
        else if (div_rsp.quotient > DIV_W'(fit_lim))
            fit_val = fit_lim;
        else
            fit_val = div_rsp.quotient[DIM_W-1:0];
        ox_diff = tgt_w_reg - fw_reg;
        oy_diff = tgt_h_reg - fh_reg;

        div_req.start    = 1'b0;
        div_req.dividend = fit_num;
        div_req.divisor  = wl_reg ? {sw, 1'b0} : {sh, 1'b0};
        gstate_next      = gstate_reg;
        case (gstate_reg)
            G_CMP:  gstate_next = G_FIT;
            G_FIT:
            begin
                div_req.start = 1'b1;
                gstate_next   = G_FITW;
            end
            G_FITW: if (div_rsp.done) gstate_next = G_RX;
            G_RX:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << RECIP_K;
                div_req.divisor  = DVS_W'(fw_reg);
                gstate_next      = G_RXW;
            end
            G_RXW:  if (div_rsp.done) gstate_next = G_RY;
            G_RY:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << RECIP_K;
                div_req.divisor  = DVS_W'(fh_reg);
                gstate_next      = G_RYW;
            end
            G_RYW:  if (div_rsp.done) gstate_next = G_IDLE;
            G_IDLE: gstate_next = G_IDLE;
            default: gstate_next = G_CMP;
        endcase
        // A configuration write restarts the whole computation.
        if (cfg_write)
            gstate_next = G_CMP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gstate_reg <= G_CMP;
        else
            gstate_reg <= gstate_next;
    end

    always_ff @(posedge clk)
    begin
        if (gstate_reg == G_CMP)
            wl_reg <= (cross_a <= cross_b);
        if ((gstate_reg == G_FITW) && div_rsp.done)
        begin
            if (wl_reg)
            begin
                fw_reg <= tgt_w_reg;
                fh_reg <= fit_val;
            end
            else
            begin
                fw_reg <= fit_val;
                fh_reg <= tgt_h_reg;
            end
        end
        if (gstate_reg == G_RX)
        begin
            ox_reg <= ox_diff[DIM_W-1:1];
            oy_reg <= oy_diff[DIM_W-1:1];
        end
        if ((gstate_reg == G_RXW) && div_rsp.done)
            rx_reg <= div_rsp.quotient;
        if ((gstate_reg == G_RYW) && div_rsp.done)
            ry_reg <= div_rsp.quotient;
    end

    assign geo_busy = (gstate_reg != G_IDLE);

    // Pipeline control: every stage moves together unless the output
    // register holds a beat that the sink is stalling.
    logic adv;
    logic accept;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv || geo_busy;
    assign accept   = in_valid && !in_stall;

    // Stages 0 to 5 carry the beat beside the position pipelines.
    side_t s_reg [6];
    logic  vld_reg [6];
    logic [SIDE_BITS-1:0] dx_reg;
    logic [SIDE_BITS-1:0] dy_reg;
    logic                 in_x;
    logic                 in_y;
    side_t                s0_next;
    side_t                s1_next;

    assign in_x = (s_reg[0].col >= ox_reg)
                  && ({1'b0, s_reg[0].col} < ({1'b0, ox_reg} + fw_reg));
    assign in_y = (s_reg[0].row >= oy_reg)
                  && ({1'b0, s_reg[0].row} < ({1'b0, oy_reg} + fh_reg));

    always_comb
    begin
        s0_next.op     = operation;
        s0_next.in_box = 1'b0;
        s0_next.col    = column;
        s0_next.row    = line;
        s0_next.pixel  = pixel_in;
        s1_next        = s_reg[0];
        s1_next.in_box = geo_active && in_x && in_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < 6; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0] <= s0_next;
            s_reg[1] <= s1_next;
            dx_reg   <= s_reg[0].col - ox_reg;
            dy_reg   <= s_reg[0].row - oy_reg;
            for (int i = 2; i < 6; i++)
                s_reg[i] <= s_reg[i-1];
        end
    end

    loc_cfg_t             loc_x_cfg;
    loc_cfg_t             loc_y_cfg;
    logic [SIDE_BITS-1:0] x0;
    logic [SIDE_BITS-1:0] x1;
    logic [SIDE_BITS-1:0] y0;
    logic [SIDE_BITS-1:0] y1;
    logic [WEIGHT_BITS-1:0] wx;
    logic [WEIGHT_BITS-1:0] wy;

    assign loc_x_cfg = '{src: sw, fit: fw_reg, recip: rx_reg};
    assign loc_y_cfg = '{src: sh, fit: fh_reg, recip: ry_reg};

    lbr_locate u_loc_x (
        .clk (clk),
        .en  (adv),
        .d   (dx_reg),
        .cfg (loc_x_cfg),
        .p0  (x0),
        .p1  (x1),
        .w   (wx)
    );

    lbr_locate u_loc_y (
        .clk (clk),
        .en  (adv),
        .d   (dy_reg),
        .cfg (loc_y_cfg),
        .p0  (y0),
        .p1  (y1),
        .w   (wy)
    );

    // Frame store in four banks by the parity of column and line, so the
    // distinct taps of one sample always fall in different banks. Loads write
    // at the same stage where samples read, which keeps the beat order.
    logic                 wr_en;
    logic [1:0]           wr_bank;
    logic [BANK_AW-1:0]   wr_addr;
    logic [PIX_W-1:0]     bank_rd [4];

    assign wr_en   = vld_reg[5] && (s_reg[5].op == OP_LOAD);
    assign wr_bank = {s_reg[5].row[0], s_reg[5].col[0]};
    assign wr_addr = {s_reg[5].row[SIDE_BITS-1:1], s_reg[5].col[SIDE_BITS-1:1]};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BX = 1'(b % 2);
        localparam logic BY = 1'(b / 2);

        logic [PIX_W-1:0]     mem [BANK_DEPTH];
        logic [PIX_W-1:0]     rd_reg;
        logic [SIDE_BITS-1:0] xs;
        logic [SIDE_BITS-1:0] ys;
        logic [BANK_AW-1:0]   raddr;

        assign xs    = (x0[0] == BX) ? x0 : x1;
        assign ys    = (y0[0] == BY) ? y0 : y1;
        assign raddr = {ys[SIDE_BITS-1:1], xs[SIDE_BITS-1:1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (wr_en && (wr_bank == 2'(b)))
                    mem[wr_addr] <= s_reg[5].pixel;
                rd_reg <= mem[raddr];
            end
        end

        assign bank_rd[b] = rd_reg;
    end

    // Stage 6: store data registered, with tap parities and weights.
    logic                   smp6_reg;
    logic                   in6_reg;
    logic                   px0_reg;
    logic                   px1_reg;
    logic                   py0_reg;
    logic                   py1_reg;
    logic [WEIGHT_BITS-1:0] wx6_reg;
    logic [WEIGHT_BITS-1:0] wy6_reg;

    // Stage 7: horizontal blends; stage 8: vertical blend.
    logic                   smp7_reg;
    logic                   in7_reg;
    logic [WEIGHT_BITS-1:0] wy7_reg;
    logic [H_W-1:0]         top_reg [3];
    logic [H_W-1:0]         bot_reg [3];
    logic                   smp8_reg;
    logic                   in8_reg;
    logic [V_W-1:0]         v_reg [3];

    // Stage 9: output register.
    logic                   inside_reg;
    logic [PIX_W-1:0]       pixel_reg;

    logic [PIX_W-1:0]       p00;
    logic [PIX_W-1:0]       p01;
    logic [PIX_W-1:0]       p10;
    logic [PIX_W-1:0]       p11;
    logic [WEIGHT_BITS:0]   wx_inv;
    logic [WEIGHT_BITS:0]   wy_inv;
    logic [H_W-1:0]         top_next [3];
    logic [H_W-1:0]         bot_next [3];
    logic [V_W-1:0]         v_next [3];
    logic [V_W:0]           rnd [3];
    logic [V_W:0]           shr [3];
    logic [PIX_W-1:0]       blend;

    always_comb
    begin
        p00    = bank_rd[{py0_reg, px0_reg}];
        p01    = bank_rd[{py0_reg, px1_reg}];
        p10    = bank_rd[{py1_reg, px0_reg}];
        p11    = bank_rd[{py1_reg, px1_reg}];
        wx_inv = ONE - (WEIGHT_BITS + 1)'(wx6_reg);
        wy_inv = ONE - (WEIGHT_BITS + 1)'(wy7_reg);
        blend  = '0;
        for (int c = 0; c < 3; c++)
        begin
            top_next[c] = H_W'(p00[8*c +: 8]) * H_W'(wx_inv)
                        + H_W'(p01[8*c +: 8]) * H_W'(wx6_reg);
            bot_next[c] = H_W'(p10[8*c +: 8]) * H_W'(wx_inv)
                        + H_W'(p11[8*c +: 8]) * H_W'(wx6_reg);
            v_next[c]   = V_W'(top_reg[c]) * V_W'(wy_inv)
                        + V_W'(bot_reg[c]) * V_W'(wy7_reg);
            rnd[c]      = (V_W + 1)'(v_reg[c]) + ((V_W + 1)'(1) << (2*WEIGHT_BITS - 1));
            shr[c]      = rnd[c] >> (2*WEIGHT_BITS);
            blend[8*c +: 8] = (shr[c] > (V_W + 1)'(255)) ? 8'hFF : shr[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp6_reg      <= 1'b0;
            smp7_reg      <= 1'b0;
            smp8_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            smp6_reg      <= vld_reg[5] && (s_reg[5].op == OP_SAMPLE);
            smp7_reg      <= smp6_reg;
            smp8_reg      <= smp7_reg;
            out_valid_reg <= smp8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in6_reg    <= s_reg[5].in_box;
            px0_reg    <= x0[0];
            px1_reg    <= x1[0];
            py0_reg    <= y0[0];
            py1_reg    <= y1[0];
            wx6_reg    <= wx;
            wy6_reg    <= wy;
            in7_reg    <= in6_reg;
            wy7_reg    <= wy6_reg;
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            in8_reg    <= in7_reg;
            v_reg      <= v_next;
            inside_reg <= in8_reg;
            pixel_reg  <= in8_reg ? blend : pad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_reg;
    assign inside_box = inside_reg;

    // A blended beat can only come from a loaded, non-empty configuration.
    a_inside_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_box) |-> geo_active)
        else $error("inside beat without an active source");

    // Once the geometry is settled the fitted box lies within the canvas.
    a_fit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (!geo_busy && geo_active) |-> ((fw_reg != '0) && (fw_reg <= tgt_w_reg)
                                       && (fh_reg != '0) && (fh_reg <= tgt_h_reg)))
        else $error("fitted box outside the canvas");

    // No beat may enter while the geometry is being recomputed.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        geo_busy |-> (in_stall && !accept))
        else $error("beat accepted during geometry update");

endmodule

`default_nettype wire

// ===== hdl/lbr_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the box geometry.
`default_nettype none

module lbr_div
    import lbr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0]       trial;
    logic                 ge;
    logic [DVS_W:0]       diff;
    logic [DVS_W-1:0]     rem_next;
    logic [DIV_W-1:0]     dvd_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd_next = {dvd_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/lbr_locate.sv =====
// Four-stage pipeline mapping a box coordinate to two source taps and a weight.
`default_nettype none

module lbr_locate
    import lbr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [SIDE_BITS-1:0]   d,
    input  wire loc_cfg_t               cfg,
    output logic [SIDE_BITS-1:0]        p0,
    output logic [SIDE_BITS-1:0]        p1,
    output logic [WEIGHT_BITS-1:0]      w
);

    localparam int PA_W  = 2 * DIM_W;
    localparam int PB_W  = N_W + RECIP_W;
    localparam int REM_W = Q_W + DIM_W;
    localparam logic [Q_W:0] HALF = (Q_W + 1)'(1 << (WEIGHT_BITS - 1));

    logic [N_W-1:0]       n_reg;
    logic [N_W-1:0]       nb_reg;
    logic [Q_W-1:0]       qe_reg;
    logic [Q_W-1:0]       q_reg;
    logic [SIDE_BITS-1:0] p0_reg;
    logic [SIDE_BITS-1:0] p1_reg;
    logic [WEIGHT_BITS-1:0] w_reg;

    logic [PA_W-1:0]      prod_a;
    logic [N_W-1:0]       n_next;
    logic [PB_W-1:0]      prod_b;
    logic [REM_W-1:0]     back;
    logic [REM_W-1:0]     rem;
    logic [Q_W-1:0]       q_next;
    logic [Q_W:0]         qs;
    logic [SIDE_BITS-1:0] base;
    logic [DIM_W-1:0]     base1;
    logic [DIM_W-1:0]     lim;

    always_comb
    begin
        // The numerator is (2d+1)*src scaled by half a weight unit.
        prod_a = PA_W'({d, 1'b1}) * PA_W'(cfg.src);
        n_next = N_W'(prod_a) << (WEIGHT_BITS - 1);
        prod_b = PB_W'(n_reg) * PB_W'(cfg.recip);
        // The reciprocal estimate is at most one low; one compare fixes it.
        back   = REM_W'(qe_reg) * REM_W'(cfg.fit);
        rem    = REM_W'(nb_reg) - back;
        q_next = qe_reg + Q_W'(rem >= REM_W'(cfg.fit));
        qs     = {1'b0, q_reg} - HALF;
        base   = qs[Q_W-1:WEIGHT_BITS];
        base1  = {1'b0, base} + 1'b1;
        lim    = cfg.src - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= n_next;
            nb_reg <= n_reg;
            qe_reg <= prod_b[RECIP_K+Q_W-1:RECIP_K];
            q_reg  <= q_next;
            w_reg  <= qs[WEIGHT_BITS-1:0];
            if (qs[Q_W])
            begin
                p0_reg <= '0;
                p1_reg <= '0;
            end
            else
            begin
                p0_reg <= ({1'b0, base} > lim) ? lim[SIDE_BITS-1:0] : base;
                p1_reg <= (base1 > lim) ? lim[SIDE_BITS-1:0] : base1[SIDE_BITS-1:0];
            end
        end
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;
    assign w  = w_reg;

endmodule

`default_nettype wire

// ===== verif/tb_letterbox_bilinear_resampler_unit.sv =====
// Self-checking testbench for the letterbox bilinear resampler unit.
`timescale 1ns / 1ps

module tb_letterbox_bilinear_resampler_unit;
    import lbr_pkg::*;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // One input beat as the stimulus generator queues it.
    typedef struct {
        logic                 op;
        logic [SIDE_BITS-1:0] col;
        logic [SIDE_BITS-1:0] row;
        logic [PIX_W-1:0]     pix;
    } beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = OP_LOAD;
    logic [SIDE_BITS-1:0]  column = '0;
    logic [SIDE_BITS-1:0]  line = '0;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  inside_box;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the block's configuration, updated at each register write.
    logic [DIM_W-1:0] src_w_reg = 9'd256;
    logic [DIM_W-1:0] src_h_reg = 9'd256;
    logic [DIM_W-1:0] tgt_w_reg = 9'd256;
    logic [DIM_W-1:0] tgt_h_reg = 9'd256;
    logic [PIX_W-1:0] pad_reg = '0;
    logic             present_reg = 1'b0;

    // Frame store copy as seen by accepted beats, and the generator's record of
    // which entries have been loaded so far, so no sample ever reads an empty one.
    logic [PIX_W-1:0] frame_copy [0:MAX_SIDE*MAX_SIDE-1];
    bit               loaded [0:MAX_SIDE*MAX_SIDE-1];

    beat_t            pending_beats[$];
    logic [PIX_W-1:0] expected_pixels[$];
    logic             expected_inside[$];

    int  error_count = 0;
    int  sender_idle_pct = 19;
    int  receiver_idle_pct = 85;
    bit  sender_pause = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    int  hold_cycles = 0;

    letterbox_bilinear_resampler_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .column(column), .line(line), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_out(pixel_out), .inside_box(inside_box),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Floor division that also holds for a negative numerator.
    function automatic longint div_floor(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Maps a box-relative index to its two neighbouring source taps and the
    // fractional weight between them, with the taps clamped to the image edge.
    task automatic source_taps(input longint d, input longint src, input longint fit,
                               output longint p0, output longint p1, output longint w);
        longint num;
        longint q;
        longint base;
        num  = (2 * d + 1) * src - fit;
        q    = div_floor(num * (1 << WEIGHT_BITS), 2 * fit);
        base = div_floor(q, 1 << WEIGHT_BITS);
        w    = q - base * (1 << WEIGHT_BITS);
        p0   = clamp_range(base, 0, src - 1);
        p1   = clamp_range(base + 1, 0, src - 1);
    endtask

    // Works out the destination pixel for one sample coordinate.
    task automatic resample_point(input longint c, input longint r,
                                  output logic [PIX_W-1:0] px, output logic ins);
        longint sw, sh, dw, dh, fw, fh, ox, oy;
        longint x0, x1, y0, y1, wx, wy;
        longint one, a, b, e, f, top, bot, v;
        int     sh_bits;
        sw  = (src_w_reg > MAX_SIDE) ? MAX_SIDE : src_w_reg;
        sh  = (src_h_reg > MAX_SIDE) ? MAX_SIDE : src_h_reg;
        dw  = tgt_w_reg;
        dh  = tgt_h_reg;
        px  = pad_reg;
        ins = 1'b0;
        if (!present_reg || sw == 0 || sh == 0 || dw == 0 || dh == 0)
            return;
        // Width-limited when the canvas is relatively narrower than the source.
        if (dw * sh <= dh * sw)
        begin
            fw = dw;
            fh = (2 * sh * dw + sw) / (2 * sw);
        end
        else
        begin
            fh = dh;
            fw = (2 * sw * dh + sh) / (2 * sh);
        end
        fw = clamp_range(fw, 1, dw);
        fh = clamp_range(fh, 1, dh);
        ox = (dw - fw) / 2;
        oy = (dh - fh) / 2;
        if (c < ox || c >= ox + fw || r < oy || r >= oy + fh)
            return;
        source_taps(c - ox, sw, fw, x0, x1, wx);
        source_taps(r - oy, sh, fh, y0, y1, wy);
        one = 1 << WEIGHT_BITS;
        px  = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sh_bits = 16 - 8 * ch;
            a   = (frame_copy[y0 * MAX_SIDE + x0] >> sh_bits) & 8'hFF;
            b   = (frame_copy[y0 * MAX_SIDE + x1] >> sh_bits) & 8'hFF;
            e   = (frame_copy[y1 * MAX_SIDE + x0] >> sh_bits) & 8'hFF;
            f   = (frame_copy[y1 * MAX_SIDE + x1] >> sh_bits) & 8'hFF;
            top = a * (one - wx) + b * wx;
            bot = e * (one - wx) + f * wx;
            v   = (top * (one - wy) + bot * wy + (1 << (2 * WEIGHT_BITS - 1)))
                  >> (2 * WEIGHT_BITS);
            if (v > 255)
                v = 255;
            px = px | (PIX_W'(v) << sh_bits);
        end
        ins = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Driver: a beat leaves the port only when accepted, and an accepted beat
    // updates the store copy or queues its expected result.
    always @(posedge clk or negedge rst_n)
    begin
        logic [PIX_W-1:0] exp_px;
        logic             exp_in;
        beat_t            nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (operation == OP_SAMPLE)
                begin
                    resample_point(column, line, exp_px, exp_in);
                    expected_pixels = {expected_pixels, exp_px};
                    expected_inside = {expected_inside, exp_in};
                end
                else
                begin
                    frame_copy[{line, column}] = pixel_in;
                end
            end
            if (in_valid && in_stall)
            begin
                // The beat is still waiting; it stays unchanged on the port.
            end
            else if (pending_beats.size() != 0 && !sender_pause
                     && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt = pending_beats.pop_front();
                in_valid  <= 1'b1;
                operation <= nxt.op;
                column    <= nxt.col;
                line      <= nxt.row;
                pixel_in  <= nxt.pix;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted here so the pipeline backs up into in_stall.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack    <= hold_req;
            hold_cycles <= 400;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= (hold_cycles != 0) || ($urandom_range(99) < receiver_idle_pct);
    end

    // Monitor: each accepted output beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        logic [PIX_W-1:0] want_px;
        logic             want_in;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat pixel %06h inside %0b",
                                          pixel_out, inside_box));
            end
            else
            begin
                want_px = expected_pixels.pop_front();
                want_in = expected_inside.pop_front();
                if (pixel_out !== want_px)
                    report_mismatch($sformatf("pixel_out %06h, expected %06h",
                                              pixel_out, want_px));
                if (inside_box !== want_in)
                    report_mismatch($sformatf("inside_box %0b, expected %0b",
                                              inside_box, want_in));
            end
        end
    end

    // Waits until every queued beat is accepted and every result has come, then
    // lets the pipeline run dry in case a trailing load is still in flight.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SOURCE_WIDTH:   src_w_reg   = val[DIM_W-1:0];
            REG_SOURCE_HEIGHT:  src_h_reg   = val[DIM_W-1:0];
            REG_TARGET_WIDTH:   tgt_w_reg   = val[DIM_W-1:0];
            REG_TARGET_HEIGHT:  tgt_h_reg   = val[DIM_W-1:0];
            REG_PAD_COLOR:      pad_reg     = val[PIX_W-1:0];
            REG_SOURCE_PRESENT: present_reg = val[0];
            default:            ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_beat(input logic op, input int c, input int r, input logic [PIX_W-1:0] p);
        beat_t b;
        b.op  = op;
        b.col = c[SIDE_BITS-1:0];
        b.row = r[SIDE_BITS-1:0];
        b.pix = p;
        if (op == OP_LOAD)
            loaded[{b.row, b.col}] = 1'b1;
        pending_beats = {pending_beats, b};
    endtask

    // Sets up one geometry and queues samples with some reloads mixed in.
    // Every source pixel the geometry can touch is loaded first.
    task automatic run_setting(input int sw, input int sh, input int dw, input int dh,
                               input logic [PIX_W-1:0] pad, input logic present,
                               input int samples);
        int ew, eh, cw, ch;
        wait_drained();
        write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(sw));
        write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(sh));
        write_reg(REG_TARGET_WIDTH, CFG_DATA_W'(dw));
        write_reg(REG_TARGET_HEIGHT, CFG_DATA_W'(dh));
        write_reg(REG_PAD_COLOR, pad);
        // The upper data bits must be masked off by the block.
        write_reg(REG_SOURCE_PRESENT, {23'($urandom_range(1, 8388607)), present});
        ew = (sw > MAX_SIDE) ? MAX_SIDE : sw;
        eh = (sh > MAX_SIDE) ? MAX_SIDE : sh;
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
                if (!loaded[y * MAX_SIDE + x])
                    queue_beat(OP_LOAD, x, y, PIX_W'($urandom_range(0, 16777215)));
        cw = (dw > MAX_SIDE) ? MAX_SIDE : ((dw == 0) ? 1 : dw);
        ch = (dh > MAX_SIDE) ? MAX_SIDE : ((dh == 0) ? 1 : dh);
        for (int i = 0; i < samples; i++)
        begin
            if ($urandom_range(99) < 15 && ew > 0 && eh > 0)
                queue_beat(OP_LOAD, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                           PIX_W'($urandom_range(0, 16777215)));
            else if ($urandom_range(99) < 10)
                queue_beat(OP_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255),
                           PIX_W'($urandom_range(0, 16777215)));
            else
                queue_beat(OP_SAMPLE, $urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                           PIX_W'($urandom_range(0, 16777215)));
        end
    endtask

    initial
    begin
        int sw, sh, dw, dh;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: no source present, so samples return the black pad.
        queue_beat(OP_SAMPLE, 0, 0, 24'hFFFFFF);
        queue_beat(OP_SAMPLE, 255, 255, 24'h000000);
        queue_beat(OP_SAMPLE, 128, 7, 24'h5A5A5A);

        // A two by two source with extreme pixels blended onto a wide canvas.
        queue_beat(OP_LOAD, 0, 0, 24'h000000);
        queue_beat(OP_LOAD, 1, 0, 24'hFFFFFF);
        queue_beat(OP_LOAD, 0, 1, 24'hFF00FF);
        queue_beat(OP_LOAD, 1, 1, 24'h00FF00);
        wait_drained();
        write_reg(REG_SOURCE_WIDTH, 24'd2);
        write_reg(REG_SOURCE_HEIGHT, 24'd2);
        write_reg(REG_TARGET_WIDTH, 24'd256);
        write_reg(REG_TARGET_HEIGHT, 24'd100);
        write_reg(REG_PAD_COLOR, 24'hFFFFFF);
        write_reg(REG_SOURCE_PRESENT, 24'd1);
        // An unknown register index must leave everything alone.
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h000001);
        queue_beat(OP_SAMPLE, 0, 0, 24'h0);
        queue_beat(OP_SAMPLE, 255, 99, 24'h0);
        queue_beat(OP_SAMPLE, 77, 0, 24'h0);
        queue_beat(OP_SAMPLE, 78, 0, 24'h0);
        queue_beat(OP_SAMPLE, 177, 99, 24'h0);
        queue_beat(OP_SAMPLE, 178, 50, 24'h0);
        queue_beat(OP_SAMPLE, 128, 50, 24'h0);
        queue_beat(OP_SAMPLE, 255, 255, 24'h0);

        // Zero-sized source or canvas, oversized source and canvas, tiny sizes.
        run_setting(0, 5, 64, 64, 24'h123456, 1'b1, 6);
        run_setting(4, 4, 0, 64, 24'hABCDEF, 1'b1, 6);
        run_setting(400, 1, 511, 5, 24'h00FF00, 1'b1, 30);
        run_setting(1, 1, 1, 1, 24'hFF0000, 1'b1, 10);

        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph == 5)
            begin
                sender_idle_pct   = 85;
                receiver_idle_pct = 19;
            end
            if (ph == 10)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            sw = $urandom_range(1, 8);
            sh = $urandom_range(1, 8);
            dw = $urandom_range(1, 256);
            dh = $urandom_range(1, 256);
            if (ph == 3)
            begin
                sw = 1;
                sh = 64;
                dw = 256;
                dh = 1;
            end
            if (ph == 12)
            begin
                sw = 256;
                sh = 1;
                dw = 256;
                dh = 256;
            end
            run_setting(sw, sh, dw, dh, PIX_W'($urandom_range(0, 16777215)),
                        ($urandom_range(9) != 0), 30);
            if (ph == 7)
            begin
                // Hold the receiver off while the sender keeps offering samples.
                hold_req = ~hold_req;
                for (int i = 0; i < 60; i++)
                    queue_beat(OP_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255), '0);
            end
            if (ph == 8)
            begin
                // Pause the sender until the block has returned every result.
                while (pending_beats.size() > 15)
                    @(posedge clk);
                sender_pause = 1'b1;
                while (in_valid || expected_pixels.size() != 0)
                    @(posedge clk);
                sender_pause = 1'b0;
            end
        end

        wait_drained();
        if (expected_pixels.size() != 0)
            report_mismatch("results still expected at end of run");
        if (error_count == 0)
            $display("** letterbox_bilinear_resampler_unit: PASSED **");
        else
            $display("** letterbox_bilinear_resampler_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results outstanding", expected_pixels.size());
        $display("** letterbox_bilinear_resampler_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lbr_pkg.sv
hdl/lbr_div.sv
hdl/lbr_locate.sv
hdl/letterbox_bilinear_resampler_unit.sv
verif/tb_letterbox_bilinear_resampler_unit.sv
